### rtl/assert_macros.svh
// Assertion macros shared by the score table RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define NSST_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define NSST_NEVER(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define NSST_ASSERT(name, clk, rst_n, prop, msg)
`define NSST_NEVER(name, clk, rst_n, prop, msg)
`endif
`endif

### rtl/nsst_pkg.sv
// Types, codes and constants for the sorted score table.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package nsst_pkg;

  // Default configuration
  localparam int TableCountDef   = 2;
  localparam int TableEntriesDef = 8;

  localparam logic [19:0] ScoreMax  = 20'd999999;
  localparam logic [31:0] EmptyName = 32'h454D_5054;  // "EMPT"

  // Opcodes
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpQuery  = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  // Read address selects
  localparam logic [2:0] RdPos     = 3'd0;  // base + pos
  localparam logic [2:0] RdPosNext = 3'd1;  // base + pos + 1
  localparam logic [2:0] RdShift   = 3'd2;  // base + k - 1
  localparam logic [2:0] RdShift2  = 3'd3;  // base + k - 2
  localparam logic [2:0] RdIdx     = 3'd4;  // base + entry index
  localparam logic [2:0] RdTop     = 3'd5;  // base

  // Write selects
  localparam logic WrShift = 1'b0;  // entry k <= entry k-1
  localparam logic WrNew   = 1'b1;  // entry pos <= new record

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  board;
    logic [19:0] score;
    logic [31:0] player_name;
    logic [2:0]  entry_index;
  } nsst_in_t;

  typedef struct packed {
    logic [3:0]  rank;
    logic        bad_board;
    logic [19:0] top_score;
    logic [19:0] entry_score;
    logic [31:0] entry_name;
  } nsst_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic       inc_pos;
    logic       init_k;
    logic       dec_k;
    logic       set_placed;
    logic       cap_top;
    logic       cap_entry;
    logic       load_out;
  } nsst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       bad_board;
    logic [1:0] opcode;
    logic       found;
    logic       pos_last;
    logic       k_gt_next;
    logic       idx_ok;
    logic       out_free;
  } nsst_sts_t;

endpackage

`default_nettype wire

### rtl/nsst_dp.sv
// Datapath: item registers, table memory with per-entry valid bits, scan and
// shift counters, result and output registers. Depends on nsst_pkg.
`default_nettype none

module nsst_dp #(
  parameter int TableCount   = nsst_pkg::TableCountDef,
  parameter int TableEntries = nsst_pkg::TableEntriesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  nsst_pkg::nsst_in_t  in_data_i,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output nsst_pkg::nsst_out_t out_data_o,
  input  nsst_pkg::nsst_cmd_t cmd_i,
  output nsst_pkg::nsst_sts_t sts_o
);
  import nsst_pkg::*;

  localparam int Slots = TableCount * TableEntries;
  localparam int AW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int PW    = $clog2(TableEntries);

  // Item registers
  logic [1:0]  op_q;
  logic [1:0]  board_q;
  logic [19:0] score_q;
  logic [31:0] name_q;
  logic [2:0]  idx_q;
  logic        bad_q;

  // Scan position and shift index
  logic [PW-1:0] pos_q;
  logic [PW-1:0] k_q;

  // Result registers
  logic        placed_q;
  logic [19:0] top_q;
  logic [19:0] escore_q;
  logic [31:0] ename_q;

  // Table memory
  logic [19:0]    score_mem [Slots];
  logic [31:0]    name_mem  [Slots];
  logic [Slots-1:0] vld_q;
  logic [19:0]    rd_score_q;
  logic [31:0]    rd_name_q;
  logic           rd_vld_q;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [19:0]   wr_score;
  logic [31:0]   wr_name;
  logic [19:0]   eff_score;
  logic [31:0]   eff_name;
  logic [19:0]   score_sat;
  logic          bad_in;

  // Output register
  logic      out_valid_q;
  nsst_out_t out_q;
  logic      out_free;

  // Saturate and range-check the incoming item
  assign score_sat = (in_data_i.score > ScoreMax) ? ScoreMax : in_data_i.score;
  assign bad_in    = int'(in_data_i.board) >= TableCount;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= in_data_i.opcode;
      board_q <= in_data_i.board;
      score_q <= score_sat;
      name_q  <= in_data_i.player_name;
      idx_q   <= in_data_i.entry_index;
      bad_q   <= bad_in;
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.load_item) begin
        pos_q <= '0;
      end else if (cmd_i.inc_pos) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.init_k) begin
        k_q <= PW'(TableEntries - 1);
      end else if (cmd_i.dec_k) begin
        k_q <= k_q - 1'b1;
      end
    end
  end

  // Never-written entries read as the reset value
  assign eff_score = rd_vld_q ? rd_score_q : '0;
  assign eff_name  = rd_vld_q ? rd_name_q  : EmptyName;

  // Address generation
  always_comb begin
    int base;
    base = int'(board_q) * TableEntries;
    case (cmd_i.rd_sel)
      RdPos:     rd_addr = AW'(base + int'(pos_q));
      RdPosNext: rd_addr = AW'(base + int'(pos_q) + 1);
      RdShift:   rd_addr = AW'(base + int'(k_q) - 1);
      RdShift2:  rd_addr = AW'(base + int'(k_q) - 2);
      RdIdx:     rd_addr = AW'(base + int'(idx_q));
      default:   rd_addr = AW'(base);
    endcase
    if (cmd_i.wr_sel == WrNew) begin
      wr_addr  = AW'(base + int'(pos_q));
      wr_score = score_q;
      wr_name  = name_q;
    end else begin
      wr_addr  = AW'(base + int'(k_q));
      wr_score = eff_score;
      wr_name  = eff_name;
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      score_mem[wr_addr] <= wr_score;
      name_mem[wr_addr]  <= wr_name;
    end
    if (cmd_i.rd_en) begin
      rd_score_q <= score_mem[rd_addr];
      rd_name_q  <= name_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // Result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      placed_q <= 1'b0;
      top_q    <= '0;
      escore_q <= '0;
      ename_q  <= '0;
    end else begin
      if (cmd_i.set_placed) begin
        placed_q <= 1'b1;
      end
      if (cmd_i.cap_top) begin
        top_q <= eff_score;
      end
      if (cmd_i.cap_entry) begin
        escore_q <= eff_score;
        ename_q  <= eff_name;
      end
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.rank        <= placed_q ? 4'(int'(pos_q) + 1) : 4'd0;
      out_q.bad_board   <= bad_q;
      out_q.top_score   <= top_q;
      out_q.entry_score <= escore_q;
      out_q.entry_name  <= ename_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to controller
  assign sts_o.bad_board = bad_q;
  assign sts_o.opcode    = op_q;
  assign sts_o.found     = eff_score <= score_q;
  assign sts_o.pos_last  = int'(pos_q) == TableEntries - 1;
  assign sts_o.k_gt_next = (int'(k_q) - 1) > int'(pos_q);
  assign sts_o.idx_ok    = int'(idx_q) < TableEntries;
  assign sts_o.out_free  = out_free;

endmodule

`default_nettype wire

### rtl/nsst_ctrl.sv
// Controller: sequences scan, shift, insert and readback for one item at a
// time. Depends on nsst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nsst_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  nsst_pkg::nsst_sts_t sts_i,
  output nsst_pkg::nsst_cmd_t cmd_o
);
  import nsst_pkg::*;

  localparam logic [3:0] SIdle     = 4'd0;
  localparam logic [3:0] SDispatch = 4'd1;
  localparam logic [3:0] SScan     = 4'd2;
  localparam logic [3:0] SShiftRd  = 4'd3;
  localparam logic [3:0] SShiftWr  = 4'd4;
  localparam logic [3:0] SIns      = 4'd5;
  localparam logic [3:0] SEntry    = 4'd6;
  localparam logic [3:0] STopRd    = 4'd7;
  localparam logic [3:0] STop      = 4'd8;
  localparam logic [3:0] SDone     = 4'd9;

  logic [3:0] state_q, state_d;
  nsst_cmd_t  cmd;

  assign in_stall_o = state_q != SIdle;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = SDispatch;
        end
      end
      SDispatch: begin
        if (sts_i.bad_board) begin
          state_d = SDone;
        end else begin
          case (sts_i.opcode)
            OpInsert, OpQuery: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RdPos;
              state_d    = SScan;
            end
            OpRead: begin
              if (sts_i.idx_ok) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RdIdx;
                state_d    = SEntry;
              end else begin
                state_d = STopRd;
              end
            end
            default: state_d = STopRd;
          endcase
        end
      end
      // One entry compared per cycle, next read issued alongside
      SScan: begin
        if (sts_i.found) begin
          cmd.set_placed = 1'b1;
          if (sts_i.opcode == OpInsert) begin
            if (!sts_i.pos_last) begin
              cmd.init_k = 1'b1;
              state_d    = SShiftRd;
            end else begin
              state_d = SIns;
            end
          end else begin
            state_d = STopRd;
          end
        end else if (sts_i.pos_last) begin
          state_d = STopRd;
        end else begin
          cmd.inc_pos = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RdPosNext;
        end
      end
      SShiftRd: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RdShift;
        state_d    = SShiftWr;
      end
      // Move one entry down per cycle, reading the next one to move
      SShiftWr: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WrShift;
        if (sts_i.k_gt_next) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RdShift2;
          cmd.dec_k  = 1'b1;
        end else begin
          state_d = SIns;
        end
      end
      SIns: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WrNew;
        state_d    = STopRd;
      end
      SEntry: begin
        cmd.cap_entry = 1'b1;
        state_d       = STopRd;
      end
      STopRd: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RdTop;
        state_d    = STop;
      end
      STop: begin
        cmd.cap_top = 1'b1;
        state_d     = SDone;
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

  // Checks
  `NSST_ASSERT(a_accept_dispatch, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == SDispatch), "accepted item not dispatched")
  `NSST_ASSERT(a_wr_insert_only, clk_i, rst_ni, cmd.wr_en |-> (sts_i.opcode == OpInsert), "table written by non-insert")
  `NSST_NEVER(a_wr_bad_board, clk_i, rst_ni, cmd.wr_en && sts_i.bad_board, "table written for bad board")
  `NSST_ASSERT(a_load_out_free, clk_i, rst_ni, cmd.load_out |-> sts_i.out_free, "output overwritten while held")

endmodule

`default_nettype wire

### rtl/top_n_sorted_score_table_core.sv
// One item in flight: the input stalls until the result is loaded into the output register
// (held back while an earlier result is stalled); a new item can be accepted the next cycle.
// A bad board goes straight to the result; other items scan, shift and insert, or read an
// entry, as the opcode asks, then read the top score. One entry compared or moved per cycle
// (one read, one write port). Reset clears control and valid bits; unwritten entries: 0, EMPT.
`default_nettype none

module top_n_sorted_score_table_core #(
  parameter int TableCount   = nsst_pkg::TableCountDef,
  parameter int TableEntries = nsst_pkg::TableEntriesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  nsst_pkg::nsst_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output nsst_pkg::nsst_out_t out_data_o
);
  import nsst_pkg::*;

  nsst_cmd_t cmd;
  nsst_sts_t sts;

  nsst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nsst_dp #(
    .TableCount   (TableCount),
    .TableEntries (TableEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for top_n_sorted_score_table_core: insert, rank query and read on
// sorted score tables, checked transfer by transfer against an in-bench table model.
// Depends on nsst_pkg and the core RTL only.
`default_nettype none

module testbench;
  import nsst_pkg::*;

  localparam int NumTables  = TableCountDef;
  localparam int NumEntries = TableEntriesDef;
  localparam int NumSlots   = NumTables * NumEntries;
  localparam int RandomItems = 550;
  localparam int CalmItems   = 80;      // tail of the run with no idling
  localparam int DrainPoint  = 300;     // sender holds off here until all replies are in
  localparam int SettleCycles = 20;     // covers the longest insert latency
  localparam int CycleLimit  = 200000;
  localparam int PrintLimit  = 40;

  // Opcode 3 has no package name; it is a no-op that still reports the top score.
  localparam logic [1:0] OpUnused = 2'd3;

  // Golden copy of the score tables plus the queue of replies still owed
  class ranked_tables;
    logic [19:0] score_of [NumSlots];
    logic [31:0] name_of [NumSlots];
    nsst_out_t   owed_replies [$];
    int mismatches, replies_checked, requests_seen, placed_inserts, rejected_boards;

    function new();
      int i;
      for (i = 0; i < NumSlots; i++) begin
        score_of[i] = '0;
        name_of[i]  = EmptyName;
      end
      mismatches = 0;
      replies_checked = 0;
      requests_seen = 0;
      placed_inserts = 0;
      rejected_boards = 0;
    endfunction

    // Apply one accepted request to the tables and queue the reply it owes
    function void accept_request(nsst_in_t req);
      nsst_out_t   want;
      logic [19:0] s;
      int base, place, p;
      want = '0;
      requests_seen++;
      if (req.board >= NumTables) begin
        want.bad_board = 1'b1;
        rejected_boards++;
      end else begin
        s = (req.score > ScoreMax) ? ScoreMax : req.score;
        base = req.board * NumEntries;
        if (req.opcode == OpInsert || req.opcode == OpQuery) begin
          // first entry at or below the new score
          place = NumEntries;
          for (p = NumEntries - 1; p >= 0; p--)
            if (score_of[base + p] <= s) place = p;
          if (place < NumEntries) begin
            want.rank = 4'(place + 1);
            if (req.opcode == OpInsert) begin
              placed_inserts++;
              for (p = NumEntries - 1; p > place; p--) begin
                score_of[base + p] = score_of[base + p - 1];
                name_of[base + p]  = name_of[base + p - 1];
              end
              score_of[base + place] = s;
              name_of[base + place]  = req.player_name;
            end
          end
        end else if (req.opcode == OpRead) begin
          if (req.entry_index < NumEntries) begin
            want.entry_score = score_of[base + req.entry_index];
            want.entry_name  = name_of[base + req.entry_index];
          end
        end
        want.top_score = score_of[base];
      end
      owed_replies.push_back(want);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got,
                               longint unsigned t);
      if (mismatches < PrintLimit)
        $display("%0t: %s mismatch, expected %0h, got %0h", t, field, want, got);
      mismatches++;
    endfunction

    // Compare one result transfer with the oldest owed reply
    function void check_reply(nsst_out_t got, longint unsigned t);
      nsst_out_t want;
      if (owed_replies.size() == 0) begin
        if (mismatches < PrintLimit)
          $display("%0t: unexpected result, expected none, got %h", t, got);
        mismatches++;
        return;
      end
      want = owed_replies.pop_front();
      replies_checked++;
      if (got.rank !== want.rank) report_field("rank", want.rank, got.rank, t);
      if (got.bad_board !== want.bad_board)
        report_field("bad_board", want.bad_board, got.bad_board, t);
      if (got.top_score !== want.top_score)
        report_field("top_score", want.top_score, got.top_score, t);
      if (got.entry_score !== want.entry_score)
        report_field("entry_score", want.entry_score, got.entry_score, t);
      if (got.entry_name !== want.entry_name)
        report_field("entry_name", want.entry_name, got.entry_name, t);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  nsst_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  nsst_out_t out_data_o;

  bit           idle_on = 1'b1;
  int unsigned  cycle_count = 0;
  ranked_tables tables = new();

  top_n_sorted_score_table_core #(
    .TableCount  (NumTables),
    .TableEntries(NumEntries)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) tables.check_reply(out_data_o, $time);

  // Receiver stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  function automatic nsst_in_t make_request(logic [1:0] op, logic [1:0] board,
                                            logic [19:0] score, logic [31:0] name,
                                            logic [2:0] idx);
    nsst_in_t req;
    req.opcode = op;
    req.board = board;
    req.score = score;
    req.player_name = name;
    req.entry_index = idx;
    return req;
  endfunction

  // Random request; the score ceiling climbs over the run so inserts keep placing
  function automatic nsst_in_t random_request(int serial);
    nsst_in_t req;
    int pick, ceiling;
    req.player_name = $urandom;
    req.entry_index = 3'($urandom_range(0, 7));
    req.board = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, NumTables - 1));
    pick = $urandom_range(0, 19);
    if (pick < 8)       req.opcode = OpInsert;
    else if (pick < 12) req.opcode = OpQuery;
    else if (pick < 19) req.opcode = OpRead;
    else                req.opcode = OpUnused;
    ceiling = 2000 + serial * 2000;
    if (ceiling > ScoreMax) ceiling = ScoreMax;
    pick = $urandom_range(0, 49);
    if (pick == 0)      req.score = 20'($urandom_range(ScoreMax, 20'hFFFFF));
    else if (pick < 4)  req.score = 20'($urandom_range(0, 20'hFFFFF));
    else if (pick < 12) req.score = 20'($urandom_range(0, 15));
    else                req.score = 20'($urandom_range(0, ceiling));
    return req;
  endfunction

  // Offer one request, with an optional idle burst first; returns at the falling edge
  task automatic send_request(input nsst_in_t req);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = req;
    do @(posedge clk_i); while (in_stall_o);
    tables.accept_request(req);
    @(negedge clk_i);
  endtask

  task automatic wait_replies_done();
    in_valid_i = 1'b0;
    while (tables.owed_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int i;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fresh tables, saturation, ties, bad boards, full table, no place
    send_request(make_request(OpRead, 0, 0, 0, 0));
    send_request(make_request(OpRead, 1, 0, 0, 7));
    send_request(make_request(OpQuery, 0, 0, 0, 0));
    send_request(make_request(OpInsert, 0, 20'hFFFFF, "SATU", 0));
    send_request(make_request(OpInsert, 0, ScoreMax, "TIES", 5));
    send_request(make_request(OpInsert, 0, 0, 32'hFFFF_FFFF, 7));
    send_request(make_request(OpInsert, 1, 20'h5A5A5, 32'h0, 0));
    send_request(make_request(OpInsert, 2, 1234, "BADB", 0));
    send_request(make_request(OpQuery, 3, 20'hFFFFF, "BADB", 7));
    send_request(make_request(OpRead, 3, 0, 0, 7));
    for (i = 0; i < 5; i++)
      send_request(make_request(OpInsert, 0, 500000, "MID0" + i, 0));
    send_request(make_request(OpInsert, 0, 1, "LOW1", 0));
    send_request(make_request(OpInsert, 0, 1, "LOW2", 0));
    send_request(make_request(OpInsert, 0, 0, "NONE", 0));
    send_request(make_request(OpQuery, 0, 0, "NONE", 0));
    send_request(make_request(OpUnused, 0, 77, "UNUS", 2));
    send_request(make_request(OpUnused, 1, 0, 0, 0));
    send_request(make_request(OpRead, 0, 0, 0, 7));
    send_request(make_request(OpRead, 1, 0, 0, 3));

    // Random traffic; one full drain partway, no idling near the end
    for (i = 0; i < RandomItems; i++) begin
      if (i == DrainPoint) wait_replies_done();
      if (i == RandomItems - CalmItems) idle_on = 1'b0;
      send_request(random_request(i));
    end

    wait_replies_done();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d requests (%0d inserts placed, %0d to missing boards); %0d results checked.",
             tables.requests_seen, tables.placed_inserts, tables.rejected_boards,
             tables.replies_checked);
    if (tables.mismatches == 0 && tables.owed_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
